### sv/basic_syntax_lexer_core_assert.svh
// Assertion macros shared by the lexer core.
`ifndef BASIC_SYNTAX_LEXER_CORE_ASSERT_SVH
`define BASIC_SYNTAX_LEXER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property that must hold at every clock edge outside reset.
`define BSL_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("bsl assertion failed");
// Condition that must never be true outside reset.
`define BSL_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("bsl forbidden condition");
`else
`define BSL_ASSERT(name, clk, rst_n, prop)
`define BSL_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

### sv/bsl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsl_pkg;

  typedef enum logic [1:0] {
    CMD_TEXT   = 2'd0,
    CMD_FLUSH  = 2'd1,
    CMD_KWRITE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_CR,
    MODE_BLANKS,
    MODE_COMMENT,
    MODE_STRING,
    MODE_PREPROC,
    MODE_WORD
  } mode_e;

  typedef enum logic [3:0] {
    KIND_NEWLINE  = 4'd0,
    KIND_BLANKS   = 4'd1,
    KIND_COMMENT  = 4'd2,
    KIND_STRING   = 4'd3,
    KIND_PREPROC  = 4'd4,
    KIND_OPERATOR = 4'd5,
    KIND_NUMBER   = 4'd6,
    KIND_KEYWORD0 = 4'd7,
    KIND_KEYWORD1 = 4'd8,
    KIND_KEYWORD2 = 4'd9,
    KIND_KEYWORD3 = 4'd10,
    KIND_IDENT    = 4'd11
  } kind_e;

  typedef enum logic {
    ENT_TOKENS,
    ENT_KWRITE
  } entry_e;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_SCAN,
    BK_EMIT0,
    BK_EMIT1
  } back_state_e;

  // Control part of one queue entry: the tokens of one input, or a table write.
  typedef struct packed {
    entry_e     typ;
    logic       two;
    logic       lookup;
    kind_e      kind0;
    kind_e      kind1;
    logic [1:0] len1;
    logic [5:0] slot;
    logic [3:0] pos;
    logic [7:0] ch;
    logic [4:0] elen;
    logic [1:0] grp;
  } q_ctl_t;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_H      = 8'h48;
  localparam logic [7:0] CH_O      = 8'h4F;
  localparam logic [7:0] CH_B      = 8'h42;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_E      = 8'h45;
  localparam logic [7:0] CH_M      = 8'h4D;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return is_lower(c) ? (c - 8'h20) : c;
  endfunction

  function automatic logic is_word_char(input logic [7:0] c);
    return is_upper(c) || is_lower(c) || is_digit(c) ||
           (c == CH_UNDER) || (c == CH_DOLLAR) || (c == CH_AMP);
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    logic r;
    r = 1'b0;
    case (c) inside
      8'h28, 8'h29, 8'h2C, 8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E,
      8'h3F, 8'h5C, 8'h5E, 8'h7B, 8'h7C, 8'h7D, 8'h7E, 8'h2B, 8'h2D, 8'h2A:
        r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/bsl_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one command per transfer.
interface bsl_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] text_char;
  logic [5:0] entry_slot;
  logic [3:0] char_pos;
  logic [4:0] entry_len;
  logic [1:0] entry_group;

  modport source (output valid, cmd, text_char, entry_slot, char_pos, entry_len,
                  entry_group, input ready);
  modport sink (input valid, cmd, text_char, entry_slot, char_pos, entry_len,
                entry_group, output ready);
endinterface

`default_nettype wire

### sv/bsl_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Output channel: one token per transfer.
interface bsl_out_if #(
  parameter int unsigned LENGTH_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [3:0]             token_kind;
  logic [LENGTH_BITS-1:0] token_length;
  logic                   run_last;

  modport source (output valid, token_kind, token_length, run_last, input ready);
  modport sink (input valid, token_kind, token_length, run_last, output ready);
endinterface

`default_nettype wire

### sv/bsl_front.sv
`timescale 1ns / 1ps
`default_nettype none

module bsl_front
  import bsl_pkg::*;
#(
  parameter int unsigned KEYWORD_MAX_LEN = 16,
  parameter int unsigned LENGTH_BITS     = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  bsl_in_if.sink                          text_i,
  input  wire                             q_full_i,
  input  wire                             busy_i,
  output logic                            q_push_o,
  output q_ctl_t                          q_ctl_o,
  output logic [LENGTH_BITS-1:0]          q_len0_o,
  output logic [KEYWORD_MAX_LEN-1:0][7:0] q_word_o
);

  localparam int unsigned PW = $clog2(KEYWORD_MAX_LEN);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] MAXLEN_L = LENGTH_BITS'(KEYWORD_MAX_LEN);

  mode_e                            mode_q, mode_d;
  logic                             ls_q, ls_d;
  logic                             ovl_q, ovl_d;
  logic [LENGTH_BITS-1:0]           cnt_q, cnt_d, cnt_inc;
  logic [KEYWORD_MAX_LEN-1:0][7:0]  buf_q;
  logic                             wb_we;
  logic [PW-1:0]                    wb_idx;
  logic                             acc;
  logic [7:0]                       c, uc;
  logic                             eol, blank;
  // Start of a new token.
  logic                             st_go, st_em, st_word, st_cnt1, st_ls;
  mode_e                            st_mode;
  kind_e                            st_kind;
  // Token that the current byte ends.
  logic                             fst_em, fst_lookup;
  kind_e                            fst_kind;
  logic [LENGTH_BITS-1:0]           fst_len;
  logic                             is_rem, is_num;
  kind_e                            word_kind;
  logic                             word_lookup;

  assign text_i.ready = !q_full_i && !busy_i;
  assign acc = text_i.valid && text_i.ready;
  assign c = text_i.text_char;
  assign uc = to_upper(c);
  assign eol = (c == CH_LF) || (c == CH_CR);
  assign blank = (c == CH_SPACE) || (c == CH_TAB);
  assign cnt_inc = (cnt_q == LEN_MAX) ? cnt_q : cnt_q + 1'b1;

  // Classification of the word held in the buffer.
  always_comb begin
    is_rem = !ovl_q && (cnt_q == LENGTH_BITS'(3)) && (buf_q[0] == CH_R) &&
             (buf_q[1] == CH_E) && (buf_q[2] == CH_M);
    is_num = is_digit(buf_q[0]) ||
             ((cnt_q >= LENGTH_BITS'(2)) && (buf_q[0] == CH_AMP) &&
              ((buf_q[1] == CH_H) || (buf_q[1] == CH_O) || (buf_q[1] == CH_B)));
    word_kind = is_num ? KIND_NUMBER : KIND_IDENT;
    word_lookup = !is_num && !ovl_q;
  end

  // What a byte does when it opens a token.
  always_comb begin
    st_mode = MODE_IDLE;
    st_em   = 1'b0;
    st_kind = KIND_IDENT;
    st_word = 1'b0;
    st_cnt1 = 1'b1;
    st_ls   = 1'b0;
    if (c == CH_LF) begin
      st_ls = 1'b1;
      st_em = 1'b1;
      st_kind = KIND_NEWLINE;
      st_cnt1 = 1'b0;
    end else if (c == CH_CR) begin
      st_ls = 1'b1;
      st_mode = MODE_CR;
    end else if (blank) begin
      st_ls = ls_q;
      st_mode = MODE_BLANKS;
    end else if (c == CH_APOS) begin
      st_mode = MODE_COMMENT;
    end else if (c == CH_QUOTE) begin
      st_mode = MODE_STRING;
    end else if ((c == CH_HASH) && ls_q) begin
      st_mode = MODE_PREPROC;
    end else if (is_op_char(c)) begin
      st_em = 1'b1;
      st_kind = KIND_OPERATOR;
      st_cnt1 = 1'b0;
    end else if (is_word_char(c)) begin
      st_mode = MODE_WORD;
      st_word = 1'b1;
    end else begin
      st_em = 1'b1;
      st_kind = KIND_IDENT;
      st_cnt1 = 1'b0;
    end
  end

  // Lexer state machine: next state and the tokens of this transfer.
  always_comb begin
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    ls_d       = ls_q;
    ovl_d      = ovl_q;
    wb_we      = 1'b0;
    wb_idx     = cnt_q[PW-1:0];
    st_go      = 1'b0;
    fst_em     = 1'b0;
    fst_kind   = KIND_IDENT;
    fst_len    = cnt_q;
    fst_lookup = 1'b0;
    if (text_i.cmd == CMD_TEXT) begin
      unique case (mode_q)
        MODE_CR: begin
          fst_em = 1'b1;
          fst_kind = KIND_NEWLINE;
          if (c == CH_LF) begin
            fst_len = LENGTH_BITS'(2);
            mode_d = MODE_IDLE;
            cnt_d = '0;
          end else begin
            fst_len = LENGTH_BITS'(1);
            st_go = 1'b1;
          end
        end
        MODE_BLANKS: begin
          if (blank) begin
            cnt_d = cnt_inc;
          end else begin
            fst_em = 1'b1;
            fst_kind = KIND_BLANKS;
            st_go = 1'b1;
          end
        end
        MODE_COMMENT, MODE_PREPROC: begin
          if (eol) begin
            fst_em = 1'b1;
            fst_kind = (mode_q == MODE_COMMENT) ? KIND_COMMENT : KIND_PREPROC;
            st_go = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            fst_em = 1'b1;
            fst_kind = KIND_STRING;
            fst_len = cnt_inc;
            mode_d = MODE_IDLE;
            cnt_d = '0;
          end else if (eol) begin
            fst_em = 1'b1;
            fst_kind = KIND_STRING;
            st_go = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        MODE_WORD: begin
          if (is_word_char(c)) begin
            if (cnt_q < MAXLEN_L) begin
              wb_we = 1'b1;
            end else begin
              ovl_d = 1'b1;
            end
            cnt_d = cnt_inc;
          end else if (is_rem) begin
            mode_d = MODE_COMMENT;
            if (eol) begin
              fst_em = 1'b1;
              fst_kind = KIND_COMMENT;
              st_go = 1'b1;
            end else begin
              cnt_d = cnt_inc;
            end
          end else begin
            fst_em = 1'b1;
            fst_kind = word_kind;
            fst_lookup = word_lookup;
            st_go = 1'b1;
          end
        end
        default: st_go = 1'b1;
      endcase
      if (st_go) begin
        mode_d = st_mode;
        cnt_d = st_cnt1 ? LENGTH_BITS'(1) : '0;
        ls_d = st_ls;
        if (st_word) begin
          wb_we = 1'b1;
          wb_idx = '0;
          ovl_d = 1'b0;
        end
      end
    end else if (text_i.cmd == CMD_FLUSH) begin
      unique case (mode_q)
        MODE_CR: begin
          fst_em = 1'b1;
          fst_kind = KIND_NEWLINE;
          fst_len = LENGTH_BITS'(1);
        end
        MODE_BLANKS: begin
          fst_em = 1'b1;
          fst_kind = KIND_BLANKS;
        end
        MODE_COMMENT: begin
          fst_em = 1'b1;
          fst_kind = KIND_COMMENT;
        end
        MODE_STRING: begin
          fst_em = 1'b1;
          fst_kind = KIND_STRING;
        end
        MODE_PREPROC: begin
          fst_em = 1'b1;
          fst_kind = KIND_PREPROC;
        end
        MODE_WORD: begin
          fst_em = 1'b1;
          fst_kind = is_rem ? KIND_COMMENT : word_kind;
          fst_lookup = !is_rem && word_lookup;
        end
        default: fst_em = 1'b0;
      endcase
      mode_d = MODE_IDLE;
      ls_d = 1'b1;
      cnt_d = '0;
      ovl_d = 1'b0;
    end
  end

  // Queue entry for this transfer.
  always_comb begin
    q_ctl_o.typ    = (text_i.cmd == CMD_KWRITE) ? ENT_KWRITE : ENT_TOKENS;
    q_ctl_o.two    = fst_em && st_go && st_em;
    q_ctl_o.lookup = fst_em && fst_lookup;
    q_ctl_o.kind0  = fst_em ? fst_kind : st_kind;
    q_ctl_o.kind1  = st_kind;
    q_ctl_o.len1   = 2'd1;
    q_ctl_o.slot   = text_i.entry_slot;
    q_ctl_o.pos    = text_i.char_pos;
    q_ctl_o.ch     = text_i.text_char;
    q_ctl_o.elen   = text_i.entry_len;
    q_ctl_o.grp    = text_i.entry_group;
    q_len0_o       = fst_em ? fst_len : LENGTH_BITS'(1);
    q_word_o       = buf_q;
    q_push_o       = acc && ((text_i.cmd == CMD_KWRITE) || fst_em || (st_go && st_em));
  end

  // Lexer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      ls_q   <= 1'b1;
      ovl_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (acc) begin
      mode_q <= mode_d;
      ls_q   <= ls_d;
      ovl_q  <= ovl_d;
      cnt_q  <= cnt_d;
    end
  end

  // Word buffer, upper-cased.
  always_ff @(posedge clk_i) begin
    if (acc && wb_we) begin
      buf_q[wb_idx] <= uc;
    end
  end

endmodule

`default_nettype wire

### sv/bsl_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module bsl_queue
  import bsl_pkg::*;
#(
  parameter int unsigned KEYWORD_MAX_LEN = 16,
  parameter int unsigned LENGTH_BITS     = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             push_i,
  input  q_ctl_t                          ctl_i,
  input  wire  [LENGTH_BITS-1:0]          len0_i,
  input  wire  [KEYWORD_MAX_LEN-1:0][7:0] word_i,
  input  wire                             pop_i,
  output logic                            full_o,
  output logic                            valid_o,
  output q_ctl_t                          ctl_o,
  output logic [LENGTH_BITS-1:0]          len0_o,
  output logic [KEYWORD_MAX_LEN-1:0][7:0] word_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  q_ctl_t                          ctl_q  [QUEUE_DEPTH];
  logic [LENGTH_BITS-1:0]          len0_q [QUEUE_DEPTH];
  logic [KEYWORD_MAX_LEN-1:0][7:0] word_q [QUEUE_DEPTH];
  logic [AW-1:0]                   wr_q, rd_q;
  logic [CW-1:0]                   cnt_q;

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign ctl_o   = ctl_q[rd_q];
  assign len0_o  = len0_q[rd_q];
  assign word_o  = word_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctl_q[wr_q]  <= ctl_i;
      len0_q[wr_q] <= len0_i;
      word_q[wr_q] <= word_i;
    end
  end

endmodule

`default_nettype wire

### sv/bsl_back.sv
`timescale 1ns / 1ps
`default_nettype none

module bsl_back
  import bsl_pkg::*;
#(
  parameter int unsigned KEYWORD_SLOTS   = 64,
  parameter int unsigned KEYWORD_MAX_LEN = 16,
  parameter int unsigned LENGTH_BITS     = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             q_valid_i,
  input  q_ctl_t                          q_ctl_i,
  input  wire  [LENGTH_BITS-1:0]          q_len0_i,
  input  wire  [KEYWORD_MAX_LEN-1:0][7:0] q_word_i,
  output logic                            q_pop_o,
  output logic                            busy_o,
  bsl_out_if.source                       token_o
);

  localparam int unsigned SW = (KEYWORD_SLOTS > 1) ? $clog2(KEYWORD_SLOTS) : 1;
  localparam int unsigned PW = $clog2(KEYWORD_MAX_LEN);
  localparam int unsigned LW = $clog2(KEYWORD_MAX_LEN + 1);

  back_state_e                     state_q, state_d;
  logic [SW-1:0]                   clr_q, clr_d;
  logic [SW:0]                     scan_q, scan_d;
  logic [2:0]                      best_q, best_d;
  logic                            cmp_vld_q, cmp_vld_d;

  // Keyword table memories.
  logic [KEYWORD_MAX_LEN-1:0][7:0] kw_chars_q [KEYWORD_SLOTS];
  logic [LW-1:0]                   kw_len_q   [KEYWORD_SLOTS];
  logic [1:0]                      kw_grp_q   [KEYWORD_SLOTS];
  logic [KEYWORD_MAX_LEN-1:0][7:0] rd_row_q;
  logic [LW-1:0]                   rd_len_q;
  logic [1:0]                      rd_grp_q;
  logic [SW-1:0]                   rd_addr;

  logic                            len_we, grp_we, chr_we;
  logic [SW-1:0]                   w_addr;
  logic [LW-1:0]                   w_len;
  logic [PW-1:0]                   w_pos;
  logic                            slot_ok;

  logic [KEYWORD_MAX_LEN-1:0]      byte_eq;
  logic                            match;
  kind_e                           lookup_kind;

  logic                            out_free, out_load, out_vld_q;
  kind_e                           out_kind_d, out_kind_q;
  logic [LENGTH_BITS-1:0]          out_len_d, out_len_q;
  logic                            out_last_d, out_last_q;

  assign busy_o = (state_q == BK_CLEAR);
  assign out_free = !out_vld_q || token_o.ready;
  assign slot_ok = (32'(q_ctl_i.slot) < KEYWORD_SLOTS);
  assign w_pos = PW'(q_ctl_i.pos);

  // Compare the table row read last cycle with the queued word.
  always_comb begin
    for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
      byte_eq[i] = (LW'(i) >= rd_len_q) || (rd_row_q[i] == q_word_i[i]);
    end
    match = (rd_len_q != '0) && (LENGTH_BITS'(rd_len_q) == q_len0_i) && (&byte_eq);
  end

  // Group of the best match found so far.
  always_comb begin
    lookup_kind = KIND_IDENT;
    if (!best_q[2]) begin
      unique case (best_q[1:0])
        2'd0: lookup_kind = KIND_KEYWORD0;
        2'd1: lookup_kind = KIND_KEYWORD1;
        2'd2: lookup_kind = KIND_KEYWORD2;
        default: lookup_kind = KIND_KEYWORD3;
      endcase
    end
  end

  // Back-end sequencer: table writes, keyword scan, token output.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    scan_d     = scan_q;
    best_d     = best_q;
    cmp_vld_d  = 1'b0;
    rd_addr    = scan_q[SW-1:0];
    len_we     = 1'b0;
    grp_we     = 1'b0;
    chr_we     = 1'b0;
    w_addr     = SW'(q_ctl_i.slot);
    w_len      = (q_ctl_i.elen > 5'(KEYWORD_MAX_LEN > 31 ? 31 : KEYWORD_MAX_LEN))
                 ? LW'(KEYWORD_MAX_LEN) : LW'(q_ctl_i.elen);
    q_pop_o    = 1'b0;
    out_load   = 1'b0;
    out_kind_d = q_ctl_i.kind0;
    out_len_d  = q_len0_i;
    out_last_d = !q_ctl_i.two;
    unique case (state_q)
      BK_CLEAR: begin
        len_we = 1'b1;
        w_addr = clr_q;
        w_len  = '0;
        clr_d  = clr_q + 1'b1;
        if (clr_q == SW'(KEYWORD_SLOTS - 1)) begin
          state_d = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          if (q_ctl_i.typ == ENT_KWRITE) begin
            len_we  = slot_ok;
            grp_we  = slot_ok;
            chr_we  = slot_ok && (32'(q_ctl_i.pos) < KEYWORD_MAX_LEN);
            q_pop_o = 1'b1;
          end else if (q_ctl_i.lookup) begin
            scan_d  = '0;
            best_d  = 3'd4;
            state_d = BK_SCAN;
          end else begin
            state_d = BK_EMIT0;
          end
        end
      end
      BK_SCAN: begin
        if (cmp_vld_q && match && ({1'b0, rd_grp_q} < best_q)) begin
          best_d = {1'b0, rd_grp_q};
        end
        if (scan_q < (SW + 1)'(KEYWORD_SLOTS)) begin
          cmp_vld_d = 1'b1;
          scan_d = scan_q + 1'b1;
        end else begin
          state_d = BK_EMIT0;
        end
      end
      BK_EMIT0: begin
        if (out_free) begin
          out_load = 1'b1;
          if (q_ctl_i.lookup) begin
            out_kind_d = lookup_kind;
          end
          if (q_ctl_i.two) begin
            state_d = BK_EMIT1;
          end else begin
            q_pop_o = 1'b1;
            state_d = BK_IDLE;
          end
        end
      end
      BK_EMIT1: begin
        out_kind_d = q_ctl_i.kind1;
        out_len_d  = LENGTH_BITS'(q_ctl_i.len1);
        out_last_d = 1'b1;
        if (out_free) begin
          out_load = 1'b1;
          q_pop_o  = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_CLEAR;
      clr_q     <= '0;
      scan_q    <= '0;
      best_q    <= 3'd4;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      scan_q    <= scan_d;
      best_q    <= best_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  // Length and group memories; the clearing pass shares the write port.
  always_ff @(posedge clk_i) begin
    if (len_we) begin
      kw_len_q[w_addr] <= w_len;
    end
    if (grp_we) begin
      kw_grp_q[w_addr] <= q_ctl_i.grp;
    end
    rd_len_q <= kw_len_q[rd_addr];
    rd_grp_q <= kw_grp_q[rd_addr];
  end

  // Character memory, one byte written per transfer, one row read per cycle.
  always_ff @(posedge clk_i) begin
    if (chr_we) begin
      kw_chars_q[w_addr][w_pos] <= q_ctl_i.ch;
    end
    rd_row_q <= kw_chars_q[rd_addr];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (token_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_len_q  <= out_len_d;
      out_last_q <= out_last_d;
    end
  end

  assign token_o.valid        = out_vld_q;
  assign token_o.token_kind   = out_kind_q;
  assign token_o.token_length = out_len_q;
  assign token_o.run_last     = out_last_q;

endmodule

`default_nettype wire

### sv/basic_syntax_lexer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer for BASIC-like source text. The front end takes one command
// per transfer (text byte, end-of-text flush or keyword table write) whenever
// the two-entry queue has room. It queues the tokens that the command completes.
// The back end writes the keyword table and sends tokens through a registered
// output. An entry with plain tokens is emitted token by token, and a table write
// is written and popped from the idle state. A word that needs a keyword lookup
// is compared against one table row per cycle. After the scan over all
// KEYWORD_SLOTS rows its token is loaded into the output register, and a second
// token that follows is loaded after it. A stalled output holds the back end, and
// a full queue stops the input. After reset the back end clears the keyword
// lengths, one slot per cycle, over all KEYWORD_SLOTS slots, and no command is
// taken during that pass.
`include "basic_syntax_lexer_core_assert.svh"

module basic_syntax_lexer_core
  import bsl_pkg::*;
#(
  parameter int unsigned KEYWORD_SLOTS   = 64,
  parameter int unsigned KEYWORD_MAX_LEN = 16,
  parameter int unsigned LENGTH_BITS     = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  bsl_in_if.sink    text_i,
  bsl_out_if.source token_o
);

  logic                            q_push, q_pop, q_full, q_valid, busy;
  q_ctl_t                          push_ctl, head_ctl;
  logic [LENGTH_BITS-1:0]          push_len0, head_len0;
  logic [KEYWORD_MAX_LEN-1:0][7:0] push_word, head_word;

  bsl_front #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
    .LENGTH_BITS    (LENGTH_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .text_i  (text_i),
    .q_full_i(q_full),
    .busy_i  (busy),
    .q_push_o(q_push),
    .q_ctl_o (push_ctl),
    .q_len0_o(push_len0),
    .q_word_o(push_word)
  );

  bsl_queue #(
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
    .LENGTH_BITS    (LENGTH_BITS)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .ctl_i  (push_ctl),
    .len0_i (push_len0),
    .word_i (push_word),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .ctl_o  (head_ctl),
    .len0_o (head_len0),
    .word_o (head_word)
  );

  bsl_back #(
    .KEYWORD_SLOTS  (KEYWORD_SLOTS),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
    .LENGTH_BITS    (LENGTH_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_ctl_i  (head_ctl),
    .q_len0_i (head_len0),
    .q_word_i (head_word),
    .q_pop_o  (q_pop),
    .busy_o   (busy),
    .token_o  (token_o)
  );

  // Cross-module checks.
  `BSL_ASSERT_NEVER(a_push_full, clk_i, rst_ni, q_push && q_full && !q_pop)
  `BSL_ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, q_pop && !q_valid)
  `BSL_ASSERT(a_no_take_clear, clk_i, rst_ni, busy |-> !q_push && !token_o.valid)

endmodule

`default_nettype wire
